// ===== hw/rtl/cipher_mac_engine_defines.svh =====
// assertion macros for the cmac engine checker
`ifndef CIPHER_MAC_ENGINE_DEFINES_SVH
`define CIPHER_MAC_ENGINE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/cme_pkg.sv =====
// ----------------------------------------------------------------------------
// cme_pkg
// types, constants and aes helpers for the cmac engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cme_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int CNT_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] CMAC_RB = 8'h87;
    localparam logic [7:0] CMAC_PAD = 8'h80;

    typedef enum logic [1:0] {
        OP_ABSORB = 2'd0,
        OP_READ   = 2'd1,
        OP_CHECK  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FINAL    = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUBKEY,
        BK_ABSORB,
        BK_FINAL,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
        logic [4:0]  byte_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] tag_hi;
        logic [63:0] tag_lo;
    } out_item_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t         op;
        logic        len_bad;
        logic [4:0]  n;
        logic [127:0] data;
        logic [127:0] mask;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } aes_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block, byte 0 in the top bits
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    // one round without the key addition: sub bytes, shift rows, optional mix columns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[c*4+i] = sbox(get_byte(s, ((c + i) % 4) * 4 + i));
            end
        end
        if (mix)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8*i -: 8] = t[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [7:0] b [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = get_byte(k, i);
        end
        b[0] = b[0] ^ sbox(b[13]) ^ rc;
        b[1] = b[1] ^ sbox(b[14]);
        b[2] = b[2] ^ sbox(b[15]);
        b[3] = b[3] ^ sbox(b[12]);
        for (int i = 4; i < 16; i++)
        begin
            b[i] = b[i] ^ b[i-4];
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8*i -: 8] = b[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, CMAC_RB} : 128'd0);
    endfunction

    // leading-byte mask for n in 0..16
    function automatic logic [127:0] lead_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
        begin
            m[127 - 8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cipher_mac_engine.sv =====
// ----------------------------------------------------------------------------
// cipher_mac_engine
// aes-128 cmac engine with absorb, read, check and clear commands
// ----------------------------------------------------------------------------
// usage: write key_high (index 0) and key_low (index 1) while idle. send
// command beats on in_valid/in_ready; each gives one result beat on
// out_valid/out_ready with a status and, for reads, the leading tag bytes.
// the front queue takes two beats while the back end works on another.
// a beat with no cipher work goes straight to the result register; a beat
// that chains a block or finalizes first runs the aes unit, and the first
// beat after reset or a key write first derives the subkeys with it. the
// aes unit is iterative, one round per cycle. reset clears message state,
// keys and subkeys. a stalled receiver holds the result register; the back
// end then waits and the front queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cipher_mac_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cme_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cme_pkg::out_item_t      out_data
);

    logic [63:0]   key_hi_reg, key_lo_reg;
    logic          cmd_valid, cmd_ready;
    cme_pkg::cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cme_pkg::reg_index_t'(cfg_index))
                cme_pkg::REG_KEY_HIGH: key_hi_reg <= cfg_data;
                cme_pkg::REG_KEY_LOW:  key_lo_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cme_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    cme_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_we),
        .key       ({key_hi_reg, key_lo_reg}),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/cme_aes_core.sv =====
// ----------------------------------------------------------------------------
// cme_aes_core
// iterative aes-128 encryption, one round per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cme_aes_core
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] key,
    input  wire logic [127:0] block_in,
    output cme_pkg::aes_ctl_t ctl,
    output logic [127:0]      block_out
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] nk;

    always_comb
    begin
        state_next = state_reg;
        rkey_next  = rkey_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        nk = cme_pkg::key_step(rkey_reg, rcon_reg);
        if (start && !busy_reg)
        begin
            state_next = block_in ^ key;
            rkey_next  = key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            state_next = cme_pkg::aes_round(state_reg, round_reg != 4'd10) ^ nk;
            rkey_next  = nk;
            rcon_next  = cme_pkg::xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd10)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign block_out = state_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cme_front.sv =====
// ----------------------------------------------------------------------------
// cme_front
// accepts beats, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cme_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cme_pkg::in_item_t in_data,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output cme_pkg::cmd_t          cmd
);

    localparam int QD = cme_pkg::QUEUE_DEPTH;
    localparam int QW = $clog2(QD);

    cme_pkg::cmd_t  q_mem [QD];
    logic [QW-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [QW:0]    cnt_reg, cnt_next;
    cme_pkg::cmd_t  cls;
    logic           push, pop;
    logic [4:0]     nsat;

    always_comb
    begin
        nsat = (in_data.byte_count > 5'(cme_pkg::BLOCK_BYTES))
            ? 5'(cme_pkg::BLOCK_BYTES) : in_data.byte_count;
        cls.op      = cme_pkg::op_t'(in_data.operation);
        cls.len_bad = (in_data.byte_count == 5'd0)
            || (in_data.byte_count > 5'(cme_pkg::BLOCK_BYTES));
        cls.n       = nsat;
        cls.data    = {in_data.data_hi, in_data.data_lo};
        cls.mask    = cme_pkg::lead_mask(nsat);
    end

    assign in_ready  = cnt_reg != (QW+1)'(QD);
    assign cmd_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? QW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop ? QW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cme_back.sv =====
// ----------------------------------------------------------------------------
// cme_back
// message state, subkey derivation, chaining and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cme_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [127:0]      key,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire cme_pkg::cmd_t     cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cme_pkg::out_item_t     out_data
);

    cme_pkg::back_state_t state_reg, state_next;
    logic [127:0] cv_reg, cv_next;
    logic [127:0] pend_reg, pend_next;
    logic [4:0]   pc_reg, pc_next;
    logic         fin_reg, fin_next;
    logic [127:0] k1_reg, k1_next, k2_reg, k2_next;
    logic         skr_reg, skr_next;
    logic         ov_reg, ov_next;
    cme_pkg::out_item_t res_reg, res_next;
    cme_pkg::cmd_t cur_reg, cur_next;
    logic         aes_start;
    logic [127:0] aes_in, aes_out;
    cme_pkg::aes_ctl_t aes_ctl;

    logic [127:0] full_blk, rest_blk, last_blk, pad_blk;
    logic [5:0]   total;
    logic [4:0]   m;

    cme_aes_core u_aes
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (aes_start),
        .key       (key),
        .block_in  (aes_in),
        .ctl       (aes_ctl),
        .block_out (aes_out)
    );

    // absorb merge: pending bytes then chunk bytes
    always_comb
    begin
        total = 6'(pc_reg) + 6'(cur_reg.n);
        m     = 5'(cme_pkg::BLOCK_BYTES) - pc_reg;
        full_blk = pend_reg | ((cur_reg.data & cur_reg.mask) >> (8 * pc_reg));
        rest_blk = (cur_reg.data & cur_reg.mask) << (8 * m);
        pad_blk  = pend_reg | ({cme_pkg::CMAC_PAD, 120'd0} >> (8 * pc_reg));
        last_blk = (pc_reg == 5'(cme_pkg::BLOCK_BYTES)) ? (pend_reg ^ k1_reg)
            : (pad_blk ^ k2_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cv_next = cv_reg; pend_next = pend_reg; pc_next = pc_reg; fin_next = fin_reg;
        k1_next = k1_reg; k2_next = k2_reg; skr_next = skr_reg;
        ov_next = ov_reg; res_next = res_reg; cur_next = cur_reg;
        aes_start = 1'b0;
        aes_in = '0;
        cmd_ready = 1'b0;
        if (out_valid && out_ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            cme_pkg::BK_IDLE:
            begin
                if (cmd_valid && !cfg_write)
                begin
                    cmd_ready = 1'b1;
                    cur_next = cmd;
                    if (!skr_reg)
                    begin
                        aes_start = 1'b1;
                        state_next = cme_pkg::BK_SUBKEY;
                    end
                    else
                    begin
                        state_next = cme_pkg::BK_RESULT;
                    end
                end
            end
            cme_pkg::BK_SUBKEY:
            begin
                if (aes_ctl.done)
                begin
                    k1_next = cme_pkg::dbl(aes_out);
                    k2_next = cme_pkg::dbl(cme_pkg::dbl(aes_out));
                    skr_next = 1'b1;
                    state_next = cme_pkg::BK_RESULT;
                end
            end
            cme_pkg::BK_RESULT:
            begin
                // decide the item; holds until the result register is free
                if (!ov_reg || out_ready)
                begin
                    res_next = '0;
                    state_next = cme_pkg::BK_IDLE;
                    priority if (cur_reg.op == cme_pkg::OP_ABSORB)
                    begin
                        if (fin_reg)
                        begin
                            res_next.status = cme_pkg::ST_FINAL;
                            ov_next = 1'b1;
                        end
                        else if (cur_reg.n != 5'd0 && total > 6'(cme_pkg::BLOCK_BYTES))
                        begin
                            aes_start = 1'b1;
                            aes_in = cv_reg ^ full_blk;
                            pend_next = rest_blk;
                            pc_next = 5'(total - 6'(cme_pkg::BLOCK_BYTES));
                            state_next = cme_pkg::BK_ABSORB;
                        end
                        else
                        begin
                            pend_next = full_blk;
                            pc_next = 5'(total);
                            ov_next = 1'b1;
                        end
                    end
                    else if (cur_reg.op == cme_pkg::OP_CLEAR)
                    begin
                        cv_next = '0; pend_next = '0; pc_next = '0; fin_next = 1'b0;
                        ov_next = 1'b1;
                    end
                    else if (cur_reg.len_bad)
                    begin
                        res_next.status = cme_pkg::ST_BAD_LEN;
                        ov_next = 1'b1;
                    end
                    else if (!fin_reg)
                    begin
                        aes_start = 1'b1;
                        aes_in = cv_reg ^ last_blk;
                        state_next = cme_pkg::BK_FINAL;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                        if (cur_reg.op == cme_pkg::OP_READ)
                        begin
                            {res_next.tag_hi, res_next.tag_lo} = cv_reg & cur_reg.mask;
                        end
                        else if (((cur_reg.data ^ cv_reg) & cur_reg.mask) != '0)
                        begin
                            res_next.status = cme_pkg::ST_MISMATCH;
                        end
                    end
                end
            end
            cme_pkg::BK_ABSORB:
            begin
                if (aes_ctl.done)
                begin
                    cv_next = aes_out;
                    ov_next = 1'b1;
                    state_next = cme_pkg::BK_IDLE;
                end
            end
            cme_pkg::BK_FINAL:
            begin
                if (aes_ctl.done)
                begin
                    cv_next = aes_out;
                    pend_next = '0; pc_next = '0; fin_next = 1'b1;
                    state_next = cme_pkg::BK_RESULT;
                end
            end
            default:
            begin
                state_next = cme_pkg::BK_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            skr_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cme_pkg::BK_IDLE;
            cv_reg <= '0; pend_reg <= '0; pc_reg <= '0; fin_reg <= 1'b0;
            k1_reg <= '0; k2_reg <= '0; skr_reg <= 1'b0; ov_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cv_reg <= cv_next; pend_reg <= pend_next; pc_reg <= pc_next;
            fin_reg <= fin_next; k1_reg <= k1_next; k2_reg <= k2_next;
            skr_reg <= skr_next; ov_reg <= ov_next; res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = res_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cme_checker.sv =====
// ----------------------------------------------------------------------------
// cme_checker
// port-level checks for the cmac engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cipher_mac_engine_defines.svh"
module cme_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire cme_pkg::out_item_t out_data
);

    logic err_beat;
    logic tag_zero;

    assign err_beat = out_valid && (out_data.status != cme_pkg::ST_OK);
    assign tag_zero = (out_data.tag_hi == '0) && (out_data.tag_lo == '0);

    `CME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `CME_ASSERT_IMP(a_tag_ok, clk, rst_n, err_beat, tag_zero)
    `CME_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
    `CME_ASSERT_IMP(a_out_known, clk, rst_n, out_valid, !$isunknown(out_data))

endmodule

bind cipher_mac_engine cme_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aes-128 cmac engine: a directed table then
// random message sequences, predicted by an in-bench cmac model with its
// own copy of key, subkeys and message state; results compared in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    cme_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cme_pkg::out_item_t out_data;

    cipher_mac_engine u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [127:0] mdl_key;
    logic [127:0] mdl_chain;
    logic [127:0] mdl_pend;
    int           mdl_pcnt;
    logic         mdl_final;
    logic [127:0] mdl_k1;
    logic [127:0] mdl_k2;
    logic         mdl_sk_ok;

    cme_pkg::out_item_t tag_queue[$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_idle = 0;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes128(input logic [127:0] blk, input logic [127:0] key);
        logic [7:0] s [16];
        logic [7:0] k [16];
        logic [7:0] t [16];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, sum;
        logic [127:0] r;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8*i -: 8] ^ key[127 - 8*i -: 8];
            k[i] = key[127 - 8*i -: 8];
        end
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    t[c*4+i] = SBOX[s[((c + i) % 4) * 4 + i]];
                end
            end
            if (rnd != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
                    sum = a0 ^ a1 ^ a2 ^ a3;
                    t[c*4]   = a0 ^ sum ^ gmul2(a0 ^ a1);
                    t[c*4+1] = a1 ^ sum ^ gmul2(a1 ^ a2);
                    t[c*4+2] = a2 ^ sum ^ gmul2(a2 ^ a3);
                    t[c*4+3] = a3 ^ sum ^ gmul2(a3 ^ a0);
                end
            end
            k[0] = k[0] ^ SBOX[k[13]] ^ rc;
            k[1] = k[1] ^ SBOX[k[14]];
            k[2] = k[2] ^ SBOX[k[15]];
            k[3] = k[3] ^ SBOX[k[12]];
            for (int i = 4; i < 16; i++)
            begin
                k[i] = k[i] ^ k[i-4];
            end
            rc = gmul2(rc);
            for (int i = 0; i < 16; i++)
            begin
                s[i] = t[i] ^ k[i];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            r[127 - 8*i -: 8] = s[i];
        end
        return r;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, cme_pkg::CMAC_RB} : 128'd0);
    endfunction

    function automatic logic [127:0] leading_bytes(input int n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
        begin
            m[127 - 8*i -: 8] = (i < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    task automatic reset_message();
        mdl_chain = '0;
        mdl_pend = '0;
        mdl_pcnt = 0;
        mdl_final = 1'b0;
    endtask

    task automatic cmac_step(input cme_pkg::in_item_t it, output cme_pkg::out_item_t res);
        logic [127:0] d;
        logic [127:0] last;
        logic [127:0] msk;
        int n;
        int m;
        d = {it.data_hi, it.data_lo};
        n = it.byte_count;
        res = '0;
        if (!mdl_sk_ok)
        begin
            mdl_k1 = gf_double(aes128('0, mdl_key));
            mdl_k2 = gf_double(mdl_k1);
            mdl_sk_ok = 1'b1;
        end
        case (cme_pkg::op_t'(it.operation))
            cme_pkg::OP_ABSORB:
            begin
                if (mdl_final)
                begin
                    res.status = cme_pkg::ST_FINAL;
                end
                else if (n != 0)
                begin
                    if (n > cme_pkg::BLOCK_BYTES)
                    begin
                        n = cme_pkg::BLOCK_BYTES;
                    end
                    if (mdl_pcnt + n <= cme_pkg::BLOCK_BYTES)
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            mdl_pend[127 - 8*(mdl_pcnt+i) -: 8] = d[127 - 8*i -: 8];
                        end
                        mdl_pcnt += n;
                    end
                    else
                    begin
                        m = cme_pkg::BLOCK_BYTES - mdl_pcnt;
                        for (int i = 0; i < m; i++)
                        begin
                            mdl_pend[127 - 8*(mdl_pcnt+i) -: 8] = d[127 - 8*i -: 8];
                        end
                        mdl_chain = aes128(mdl_chain ^ mdl_pend, mdl_key);
                        mdl_pend = '0;
                        for (int i = m; i < n; i++)
                        begin
                            mdl_pend[127 - 8*(i-m) -: 8] = d[127 - 8*i -: 8];
                        end
                        mdl_pcnt = n - m;
                    end
                end
            end
            cme_pkg::OP_CLEAR:
            begin
                reset_message();
            end
            default:
            begin
                if (n == 0 || n > cme_pkg::BLOCK_BYTES)
                begin
                    res.status = cme_pkg::ST_BAD_LEN;
                end
                else
                begin
                    if (!mdl_final)
                    begin
                        last = mdl_pend;
                        if (mdl_pcnt == cme_pkg::BLOCK_BYTES)
                        begin
                            last = last ^ mdl_k1;
                        end
                        else
                        begin
                            last[127 - 8*mdl_pcnt -: 8] = cme_pkg::CMAC_PAD;
                            for (int i = mdl_pcnt + 1; i < 16; i++)
                            begin
                                last[127 - 8*i -: 8] = 8'h00;
                            end
                            last = last ^ mdl_k2;
                        end
                        mdl_chain = aes128(mdl_chain ^ last, mdl_key);
                        mdl_pend = '0;
                        mdl_pcnt = 0;
                        mdl_final = 1'b1;
                    end
                    msk = leading_bytes(n);
                    if (cme_pkg::op_t'(it.operation) == cme_pkg::OP_READ)
                    begin
                        {res.tag_hi, res.tag_lo} = mdl_chain & msk;
                    end
                    else if (((d ^ mdl_chain) & msk) != '0)
                    begin
                        res.status = cme_pkg::ST_MISMATCH;
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("error %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tag_queue.size() == 0)
            begin
                report_mismatch("unexpected beat status", out_data.status, 0);
            end
            else
            begin
                if (out_data.status !== tag_queue[0].status)
                begin
                    report_mismatch("status", out_data.status, tag_queue[0].status);
                end
                if (out_data.tag_hi !== tag_queue[0].tag_hi)
                begin
                    report_mismatch("tag_hi", out_data.tag_hi, tag_queue[0].tag_hi);
                end
                if (out_data.tag_lo !== tag_queue[0].tag_lo)
                begin
                    report_mismatch("tag_lo", out_data.tag_lo, tag_queue[0].tag_lo);
                end
                void'(tag_queue.pop_front());
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic write_key(input cme_pkg::reg_index_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == cme_pkg::REG_KEY_HIGH)
        begin
            mdl_key[127:64] = val;
        end
        else
        begin
            mdl_key[63:0] = val;
        end
        mdl_sk_ok = 1'b0;
    endtask

    // called at a falling edge
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tag_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    // called at a falling edge; returns at a falling edge after acceptance
    // with valid still high, so the caller drops it before waiting
    task automatic send_beat(input cme_pkg::in_item_t it, input logic has_want,
                             input cme_pkg::out_item_t want);
        cme_pkg::out_item_t res;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        cmac_step(it, res);
        if (has_want && res !== want)
        begin
            report_mismatch("table row", res.tag_hi, want.tag_hi);
        end
        tag_queue.push_back(res);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic cme_pkg::in_item_t rand_item(input cme_pkg::op_t op, input int lo,
                                                    input int hi);
        cme_pkg::in_item_t it;
        it.operation = op;
        it.data_hi = rand64();
        it.data_lo = rand64();
        it.byte_count = 5'($urandom_range(hi, lo));
        return it;
    endfunction

    typedef struct {
        cme_pkg::in_item_t  beat;
        logic               has_want;
        cme_pkg::out_item_t want;
    } row_t;

    initial
    begin
        row_t               rows[$];
        cme_pkg::in_item_t  it;
        cme_pkg::out_item_t noval;
        int                 sent;
        int                 len;
        noval = '0;
        mdl_key = '0;
        mdl_sk_ok = 1'b0;
        mdl_k1 = '0;
        mdl_k2 = '0;
        reset_message();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // standard rfc 4493 key
        write_key(cme_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(cme_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);

        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd16}, 1'b1,
                         '{cme_pkg::ST_OK, 64'hbb1d6929e9593728, 64'h7fa37d129b756746}});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'h0, 64'h0, 5'd0}, 1'b1,
                         '{cme_pkg::ST_FINAL, 64'h0, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd0}, 1'b1,
                         '{cme_pkg::ST_BAD_LEN, 64'h0, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_CHECK, 64'h0, 64'h0, 5'd17}, 1'b1,
                         '{cme_pkg::ST_BAD_LEN, 64'h0, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_CHECK, 64'hbb1d6929e9593728, 64'h0, 5'd8}, 1'b1,
                         noval});
        rows.push_back('{'{cme_pkg::OP_CHECK, 64'hbb1d6929e9593729, 64'h0, 5'd8}, 1'b1,
                         '{cme_pkg::ST_MISMATCH, 64'h0, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd1}, 1'b1,
                         '{cme_pkg::ST_OK, 64'hbb00000000000000, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_CLEAR, 64'hffffffffffffffff, 64'hffffffffffffffff,
                           5'd31}, 1'b1, noval});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'h6bc1bee22e409f96, 64'he93d7e117393172a,
                           5'd16}, 1'b1, noval});
        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd16}, 1'b1,
                         '{cme_pkg::ST_OK, 64'h070a16b46b4d4144, 64'hf79bdd9dd04a287c}});
        rows.push_back('{'{cme_pkg::OP_CLEAR, 64'h0, 64'h0, 5'd0}, 1'b1, noval});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'hffffffffffffffff, 64'hffffffffffffffff,
                           5'd31}, 1'b0, noval});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'h0123456789abcdef, 64'hfedcba9876543210,
                           5'd3}, 1'b0, noval});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'h0, 64'h0, 5'd0}, 1'b1, noval});
        rows.push_back('{'{cme_pkg::OP_ABSORB, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                           5'd15}, 1'b0, noval});
        rows.push_back('{'{cme_pkg::OP_CHECK, 64'hffffffffffffffff, 64'hffffffffffffffff,
                           5'd16}, 1'b0, noval});
        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd31}, 1'b1,
                         '{cme_pkg::ST_BAD_LEN, 64'h0, 64'h0}});
        rows.push_back('{'{cme_pkg::OP_READ, 64'h0, 64'h0, 5'd9}, 1'b0, noval});
        rows.push_back('{'{cme_pkg::OP_CLEAR, 64'h0, 64'h0, 5'd0}, 1'b1, noval});

        foreach (rows[i])
        begin
            send_beat(rows[i].beat, rows[i].has_want, rows[i].want);
        end
        wait_idle();

        sent = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 20 : (phase == 1) ? 86 : 0;
            recv_idle = (phase == 0) ? 86 : (phase == 1) ? 20 : 0;
            // key settings: extremes then random
            write_key(cme_pkg::REG_KEY_HIGH,
                      (phase == 0) ? 64'h0 : (phase == 1) ? '1 : rand64());
            write_key(cme_pkg::REG_KEY_LOW,
                      (phase == 0) ? '1 : (phase == 1) ? 64'h0 : rand64());
            while (sent < 620 * (phase + 1))
            begin
                // mostly well-formed messages, some noise
                if ($urandom_range(9) < 8)
                begin
                    send_beat(rand_item(cme_pkg::OP_CLEAR, 0, 31), 1'b0, noval);
                    len = $urandom_range(6);
                    for (int j = 0; j < len; j++)
                    begin
                        send_beat(rand_item(cme_pkg::OP_ABSORB, 0,
                                            ($urandom_range(9) == 0) ? 31 : 16),
                                  1'b0, noval);
                    end
                    sent += len + 1;
                    if ($urandom_range(1))
                    begin
                        send_beat(rand_item(cme_pkg::OP_READ, 1, 16), 1'b0, noval);
                        sent++;
                    end
                    it = rand_item(cme_pkg::OP_CHECK, 1, 16);
                    if ($urandom_range(1))
                    begin
                        {it.data_hi, it.data_lo} = aes128('0, '0) ^ mdl_chain;
                        if (mdl_final)
                        begin
                            {it.data_hi, it.data_lo} = mdl_chain;
                        end
                    end
                    send_beat(it, 1'b0, noval);
                    send_beat(rand_item(cme_pkg::op_t'($urandom_range(3)), 0, 31),
                              1'b0, noval);
                    sent += 2;
                end
                else
                begin
                    send_beat(rand_item(cme_pkg::op_t'($urandom_range(3)), 0, 31),
                              1'b0, noval);
                    sent++;
                end
                if ($urandom_range(99) == 0)
                begin
                    // hold off until the engine drains
                    in_valid <= 1'b0;
                    while (tag_queue.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
            end
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("cipher_mac_engine: match");
        end
        else
        begin
            $display("cipher_mac_engine: mismatch");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("cipher_mac_engine: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
